FILE: src/ukv_pkg.sv
package ukv_pkg;

  // Default sizes of the table.
  localparam int unsigned Capacity  = 16;
  localparam int unsigned KeyWidth  = 32;
  localparam int unsigned DataWidth = 32;

  // Request operation codes.
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_UPDATE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Control part of the request token that walks the cell row.
  typedef struct packed {
    logic valid;
    op_e  op;
    logic hit;
    logic free_found;
  } tok_ctl_t;

  // Broadcast sent to every cell when the token leaves the last cell.
  typedef struct packed {
    logic done;
    logic commit;
  } cell_cmd_t;

endpackage

FILE: src/ukv_cell.sv
module ukv_cell #(
  parameter int unsigned KeyWidth  = ukv_pkg::KeyWidth,
  parameter int unsigned DataWidth = ukv_pkg::DataWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  ukv_pkg::cell_cmd_t   cmd_i,
  input  ukv_pkg::tok_ctl_t    ctl_i,
  input  logic [KeyWidth-1:0]  key_i,
  input  logic [DataWidth-1:0] data_i,
  input  logic [DataWidth-1:0] rdata_i,
  output ukv_pkg::tok_ctl_t    ctl_o,
  output logic [KeyWidth-1:0]  key_o,
  output logic [DataWidth-1:0] data_o,
  output logic [DataWidth-1:0] rdata_o
);
  import ukv_pkg::*;

  logic                 valid_q;
  logic                 pend_q;
  logic [KeyWidth-1:0]  key_q;
  logic [DataWidth-1:0] data_q;

  tok_ctl_t             ctl_d, ctl_q;
  logic [KeyWidth-1:0]  key_tq;
  logic [DataWidth-1:0] data_tq;
  logic [DataWidth-1:0] rdata_d, rdata_q;

  logic match;
  logic claim;
  logic act;

  // Compare the passing key with this entry and decide whether to claim it.
  assign act   = en_i && ctl_i.valid;
  assign match = valid_q && (key_q == key_i);
  assign claim = (ctl_i.op == OP_INSERT) && !ctl_i.free_found && !valid_q;

  always_comb begin
    ctl_d   = ctl_i;
    rdata_d = rdata_i;
    if (ctl_i.valid && match) begin
      ctl_d.hit = 1'b1;
    end
    if (ctl_i.valid && claim) begin
      ctl_d.free_found = 1'b1;
    end
    if (ctl_i.valid && match && (ctl_i.op == OP_LOOKUP)) begin
      rdata_d = data_q;
    end
  end

  // Entry control state: a claimed entry becomes valid only on commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      if (cmd_i.done) begin
        if (cmd_i.commit && pend_q) begin
          valid_q <= 1'b1;
        end
        pend_q <= 1'b0;
      end
      if (act) begin
        case (ctl_i.op)
          OP_INSERT: if (claim) pend_q <= 1'b1;
          OP_REMOVE: if (match) valid_q <= 1'b0;
          OP_CLEAR:  valid_q <= 1'b0;
          default:   ;
        endcase
      end
    end
  end

  // Entry payload: key and data written by a claim, data by an update hit.
  always_ff @(posedge clk_i) begin
    if (act && claim) begin
      key_q  <= key_i;
      data_q <= data_i;
    end else if (act && match && (ctl_i.op == OP_UPDATE)) begin
      data_q <= data_i;
    end
  end

  // Token register handed on to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_tq  <= key_i;
      data_tq <= data_i;
      rdata_q <= rdata_d;
    end
  end

  assign ctl_o   = ctl_q;
  assign key_o   = key_tq;
  assign data_o  = data_tq;
  assign rdata_o = rdata_q;

endmodule

FILE: src/unique_key_value_table.sv
// Channel   Direction  Handshake                Fields
// request   in         in_valid_i / in_stall_o   op_i, key_i, data_in_i
// result    out        out_valid_o / out_stall_i status_o, data_out_o
//
// A request word walks the row of CAPACITY cells, one cell per cycle while the
// row is not held by a stalled result; a new word is taken only after the
// previous one has left the last cell and written its result.
// Reset empties the table; stored keys and data are not cleared.
// A stalled result holds the row, and a new request may be taken while a
// finished result still waits in the output register.
module unique_key_value_table #(
  parameter int unsigned Capacity  = ukv_pkg::Capacity,
  parameter int unsigned KeyWidth  = ukv_pkg::KeyWidth,
  parameter int unsigned DataWidth = ukv_pkg::DataWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           op_i,
  input  logic [KeyWidth-1:0]  key_i,
  input  logic [DataWidth-1:0] data_in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [DataWidth-1:0] data_out_o
);
  import ukv_pkg::*;

  tok_ctl_t             ctl_w   [Capacity+1];
  logic [KeyWidth-1:0]  key_w   [Capacity+1];
  logic [DataWidth-1:0] data_w  [Capacity+1];
  logic [DataWidth-1:0] rdata_w [Capacity+1];

  logic                 busy_q;
  tok_ctl_t             head_ctl_q;
  logic [KeyWidth-1:0]  head_key_q;
  logic [DataWidth-1:0] head_data_q;

  logic                 out_valid_q;
  status_e              out_status_q;
  logic [DataWidth-1:0] out_data_q;

  logic      accept;
  logic      en;
  logic      finish;
  tok_ctl_t  tail;
  cell_cmd_t cmd;
  status_e   status_d;
  logic [DataWidth-1:0] data_d;

  // The row moves unless a finished token meets an occupied, stalled output.
  assign tail   = ctl_w[Capacity];
  assign en     = !(tail.valid && out_valid_q && out_stall_i);
  assign finish = tail.valid && en;
  assign accept = in_valid_i && !busy_q;

  assign in_stall_o = busy_q;

  // Request register in front of the first cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      head_ctl_q <= '0;
    end else begin
      if (accept) begin
        busy_q           <= 1'b1;
        head_ctl_q.valid <= 1'b1;
        head_ctl_q.op    <= op_e'(op_i);
        head_ctl_q.hit   <= 1'b0;
        head_ctl_q.free_found <= 1'b0;
      end else begin
        if (en) begin
          head_ctl_q.valid <= 1'b0;
        end
        if (finish) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      head_key_q  <= key_i;
      head_data_q <= data_in_i;
    end
  end

  assign ctl_w[0]   = head_ctl_q;
  assign key_w[0]   = head_key_q;
  assign data_w[0]  = head_data_q;
  assign rdata_w[0] = '0;

  // An insert commits its claimed entry only when the key was absent.
  assign cmd.done   = finish;
  assign cmd.commit = (tail.op == OP_INSERT) && !tail.hit && tail.free_found;

  // Row of entry cells.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    ukv_cell #(
      .KeyWidth (KeyWidth),
      .DataWidth(DataWidth)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cmd_i  (cmd),
      .ctl_i  (ctl_w[i]),
      .key_i  (key_w[i]),
      .data_i (data_w[i]),
      .rdata_i(rdata_w[i]),
      .ctl_o  (ctl_w[i+1]),
      .key_o  (key_w[i+1]),
      .data_o (data_w[i+1]),
      .rdata_o(rdata_w[i+1])
    );
  end

  // Result from the gathered token.
  always_comb begin
    status_d = ST_OK;
    data_d   = '0;
    case (tail.op)
      OP_INSERT: begin
        if (tail.hit) begin
          status_d = ST_PRESENT;
        end else if (!tail.free_found) begin
          status_d = ST_FULL;
        end
      end
      OP_REMOVE, OP_UPDATE: begin
        if (!tail.hit) begin
          status_d = ST_NOT_FOUND;
        end
      end
      OP_LOOKUP: begin
        if (tail.hit) begin
          data_d = rdata_w[Capacity];
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_status_q <= status_d;
      out_data_q   <= data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign data_out_o  = out_data_q;

endmodule

FILE: tb/tb_unique_key_value_table.sv
module tb_unique_key_value_table;
  import ukv_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned PoolSize   = 24;
  localparam int unsigned RandomReqs = 1250;

  // One expected answer of the table.
  typedef struct {
    status_e                status;
    logic [DataWidth-1:0] data;
  } answer_t;

  // Shadow copy of the table that predicts every answer in request order.
  class kv_shadow_table;
    logic                 used[Capacity];
    logic [KeyWidth-1:0]  keys[Capacity];
    logic [DataWidth-1:0] words[Capacity];
    answer_t              awaited_answers[$];
    int                   errors;

    function new();
      foreach (used[i]) begin
        used[i]  = 1'b0;
        keys[i]  = '0;
        words[i] = '0;
      end
      errors = 0;
    endfunction

    function int pending();
      return awaited_answers.size();
    endfunction

    // Apply one accepted request word to the shadow and queue its answer.
    function void accept_request(logic [2:0] op, logic [KeyWidth-1:0] key,
                                 logic [DataWidth-1:0] din);
      int      hit;
      int      slot;
      answer_t ans;
      hit = -1;
      slot = -1;
      ans.status = ST_OK;
      ans.data = '0;
      for (int i = 0; i < Capacity; i++) begin
        if (hit < 0 && used[i] && keys[i] == key) hit = i;
        if (slot < 0 && !used[i]) slot = i;
      end
      case (op)
        OP_INSERT: begin
          if (hit >= 0) begin
            ans.status = ST_PRESENT;
          end else if (slot < 0) begin
            ans.status = ST_FULL;
          end else begin
            used[slot]  = 1'b1;
            keys[slot]  = key;
            words[slot] = din;
          end
        end
        OP_REMOVE: begin
          if (hit < 0) ans.status = ST_NOT_FOUND;
          else used[hit] = 1'b0;
        end
        OP_LOOKUP: begin
          if (hit < 0) ans.status = ST_NOT_FOUND;
          else ans.data = words[hit];
        end
        OP_UPDATE: begin
          if (hit < 0) ans.status = ST_NOT_FOUND;
          else words[hit] = din;
        end
        OP_CLEAR: begin
          foreach (used[i]) used[i] = 1'b0;
        end
        default: begin
          // Unused codes leave the table alone and answer ok with zero data.
        end
      endcase
      awaited_answers.push_back(ans);
    endfunction

    // Compare one accepted result word with the oldest awaited answer.
    function void check_response(logic [1:0] status, logic [DataWidth-1:0] data);
      answer_t ans;
      if (awaited_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual status %0d data %h",
                 $time, status, data);
        return;
      end
      ans = awaited_answers.pop_front();
      if (status !== ans.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, ans.status, status);
      end
      if (data !== ans.data) begin
        errors++;
        $display("%0t: data_out mismatch, expected %h, actual %h",
                 $time, ans.data, data);
      end
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [2:0]           op_i        = '0;
  logic [KeyWidth-1:0]  key_i       = '0;
  logic [DataWidth-1:0] data_in_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [1:0]           status_o;
  logic [DataWidth-1:0] data_out_o;

  kv_shadow_table       shadow;
  logic [KeyWidth-1:0]  key_pool[PoolSize];
  int                   calm_left  = 0;
  int                   stall_run  = 0;
  int                   free_run   = 0;
  int unsigned          cycles     = 0;

  unique_key_value_table u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .key_i       (key_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_out_o  (data_out_o)
  );

  // Free-running clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Abort a run that hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side stalls in bursts, mostly short, sometimes long, with calm stretches.
  always @(posedge clk_i) begin
    int roll;
    if (stall_run > 0) begin
      stall_run--;
      out_stall_i <= 1'b1;
    end else if (free_run > 0) begin
      free_run--;
      out_stall_i <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        free_run  = $urandom_range(100, 300);
        stall_run = 0;
      end else begin
        free_run  = $urandom_range(0, 6);
        stall_run = (roll < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      out_stall_i <= 1'b0;
    end
  end

  // Every result word taken off the output goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      shadow.check_response(status_o, data_out_o);
  end

  // Idle cycles before the next request word.
  function automatic int pick_gap();
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      calm_left = $urandom_range(30, 80);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one request word and hold it until the table accepts it.
  task automatic send_request(logic [2:0] op, logic [KeyWidth-1:0] key,
                              logic [DataWidth-1:0] din);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    key_i      <= key;
    data_in_i  <= din;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    shadow.accept_request(op, key, din);
  endtask

  // Drop valid and wait until every awaited answer has come back.
  task automatic drain_answers();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (shadow.pending() != 0) @(posedge clk_i);
  endtask

  // Keys mostly come from a small pool so that hits and a full table are common.
  function automatic logic [KeyWidth-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  initial begin
    int          roll;
    logic [2:0]  op;
    shadow = new();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) key_pool[i] = $urandom;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: misses on an empty table, extreme keys and data.
    send_request(OP_LOOKUP, '0, $urandom);
    send_request(OP_REMOVE, '0, $urandom);
    send_request(OP_UPDATE, '0, $urandom);
    send_request(OP_INSERT, '0, '1);
    send_request(OP_INSERT, '1, '0);
    send_request(OP_INSERT, '0, 32'h1234_5678);
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_LOOKUP, '1, '1);
    send_request(OP_UPDATE, '1, 32'hA5A5_A5A5);
    send_request(OP_LOOKUP, '1, '0);
    send_request(OP_REMOVE, '0, '0);
    send_request(OP_LOOKUP, '0, '0);

    // Fill the table, then probe it while it is full.
    for (int i = 1; i < Capacity; i++) send_request(OP_INSERT, 32'h1111_1111 * i, $urandom);
    send_request(OP_INSERT, 32'h0BAD_F00D, $urandom);
    send_request(OP_INSERT, '1, $urandom);
    send_request(3'd5, '1, '1);
    send_request(3'd6, $urandom, $urandom);
    send_request(3'd7, '1, '1);
    send_request(OP_CLEAR, '1, '1);
    send_request(OP_LOOKUP, '1, '0);
    send_request(OP_INSERT, 32'h0BAD_F00D, '1);

    // Random part.
    for (int n = 0; n < RandomReqs; n++) begin
      if (n == RandomReqs / 2) drain_answers();
      roll = $urandom_range(0, 99);
      if (roll < 35)      op = OP_INSERT;
      else if (roll < 50) op = OP_REMOVE;
      else if (roll < 75) op = OP_LOOKUP;
      else if (roll < 90) op = OP_UPDATE;
      else if (roll < 93) op = OP_CLEAR;
      else if (roll < 97) op = 3'($urandom_range(5, 7));
      else                op = 3'($urandom);
      send_request(op, pick_key(), $urandom);
    end

    // Let the pipeline empty out, plus a margin for stray words.
    drain_answers();
    repeat (Capacity + 4) @(posedge clk_i);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
